// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the unranking block.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PUSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define PUSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define PUSC_ASSERT(lbl, prop)
`define PUSC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/pusc_pkg.sv
// Package of the permutation unranking block: widths, types and the factorial table.
// No dependencies.
package pusc_pkg;

  localparam int MAX_ORDER = 16;
  localparam int RANK_W    = 41;
  localparam int ELEM_W    = 4;
  localparam int ORDER_W   = 5;
  localparam int POOL_N    = MAX_ORDER - 1;
  localparam logic [ORDER_W-1:0] MinOrder = 5'd4;
  localparam logic [ORDER_W-1:0] MaxOrder = ORDER_W'(MAX_ORDER);

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic               err;
    logic [ORDER_W-1:0] order;
  } queue_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } back_state_e;

  function automatic logic [RANK_W-1:0] fact_of(input logic [ELEM_W-1:0] k);
    logic [RANK_W-1:0] f;
    case (k)
      4'd0:    f = 41'd1;
      4'd1:    f = 41'd1;
      4'd2:    f = 41'd2;
      4'd3:    f = 41'd6;
      4'd4:    f = 41'd24;
      4'd5:    f = 41'd120;
      4'd6:    f = 41'd720;
      4'd7:    f = 41'd5040;
      4'd8:    f = 41'd40320;
      4'd9:    f = 41'd362880;
      4'd10:   f = 41'd3628800;
      4'd11:   f = 41'd39916800;
      4'd12:   f = 41'd479001600;
      4'd13:   f = 41'd6227020800;
      4'd14:   f = 41'd87178291200;
      default: f = 41'd1307674368000;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/pusc_front.sv
// Front part: holds the group order register and classifies each request.
// Depends on pusc_pkg.
module pusc_front import pusc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ORDER_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [RANK_W-1:0]  perm_index_i,
  input  queue_status_t      q_status_i,
  output logic               push_o,
  output queue_entry_t       push_entry_o
);

  logic [ORDER_W-1:0] order_q;
  logic [ORDER_W-1:0] order_eff;
  logic [ORDER_W-1:0] m_wide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= MinOrder;
    end else if (cfg_valid_i && cfg_ready_o) begin
      order_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (order_q < MinOrder) begin
      order_eff = MinOrder;
    end else if (order_q > MaxOrder) begin
      order_eff = MaxOrder;
    end else begin
      order_eff = order_q;
    end
    m_wide = order_eff - 5'd1;
  end

  assign cfg_ready_o        = 1'b1;
  assign in_stall_o         = q_status_i.full;
  assign push_o             = in_valid_i && !q_status_i.full;
  assign push_entry_o.rank  = perm_index_i;
  assign push_entry_o.order = order_eff;
  assign push_entry_o.err   = perm_index_i >= fact_of(m_wide[ELEM_W-1:0]);

endmodule

// File: rtl/pusc_queue.sv
// Two-entry queue of classified requests between the front and back parts.
// Depends on pusc_pkg.
module pusc_queue import pusc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  queue_entry_t  push_entry_i,
  input  logic          pop_i,
  output queue_entry_t  head_o,
  output queue_status_t status_o
);

  queue_entry_t mem_q [2];
  logic         wr_q, wr_d;
  logic         rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.empty = cnt_q == 2'd0;
  assign status_o.full  = cnt_q == 2'd2;

endmodule

// File: rtl/pusc_back.sv
// Back part: digit extraction by restoring division, pool removal and prefix-sum check.
// Depends on pusc_pkg.
module pusc_back import pusc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  queue_status_t      q_status_i,
  input  queue_entry_t       head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ELEM_W-1:0]  element_o,
  output logic [ELEM_W-1:0]  position_o,
  output logic               last_o,
  output logic               sequencing_ok_o,
  output logic               index_error_o
);

  back_state_e        state_q, state_d;
  logic [RANK_W-1:0]  rank_q, rank_d;
  logic [ORDER_W-1:0] order_q, order_d;
  logic [ELEM_W-1:0]  m_q, m_d;
  logic [ELEM_W-1:0]  pos_q, pos_d;
  logic [1:0]         bit_q, bit_d;
  logic [ELEM_W-1:0]  digit_q, digit_d;
  logic [ELEM_W-1:0]  pool_q [POOL_N];
  logic [ELEM_W-1:0]  pool_d [POOL_N];
  logic [MAX_ORDER-1:0] seen_q, seen_d;
  logic [ELEM_W-1:0]  sum_q, sum_d;
  logic               ok_q, ok_d;

  logic               ovalid_q, ovalid_d;
  logic [ELEM_W-1:0]  oelem_q, oelem_d;
  logic [ELEM_W-1:0]  opos_q, opos_d;
  logic               olast_q, olast_d;
  logic               ook_q, ook_d;
  logic               oerr_q, oerr_d;

  logic               out_free;
  logic [ELEM_W-1:0]  rem;
  logic [RANK_W+2:0]  trial;
  logic [ELEM_W-1:0]  di;
  logic [ELEM_W-1:0]  val;
  logic [ORDER_W-1:0] sum_wide;
  logic [ELEM_W-1:0]  sum_new;
  logic               is_last;
  logic               ok_new;
  logic [ORDER_W-1:0] m_wide;

  assign out_free = !ovalid_q || !out_stall_i;
  assign rem      = m_q - 4'd1 - pos_q;
  assign trial    = {3'b000, fact_of(rem)} << bit_q;
  assign di       = (digit_q > rem) ? rem : digit_q;
  assign val      = pool_q[di];
  assign sum_wide = {1'b0, sum_q} + {1'b0, val};
  assign sum_new  = (sum_wide >= order_q) ? 4'(sum_wide - order_q) : sum_wide[ELEM_W-1:0];
  assign is_last  = pos_q == m_q - 4'd1;
  assign ok_new   = ok_q && !seen_q[sum_new];
  assign m_wide   = head_i.order - 5'd1;
  assign pop_o    = (state_q == ST_IDLE) && !q_status_i.empty;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = head_i.err ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_q == 2'd0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = is_last ? ST_IDLE : ST_DIV;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rank_d   = rank_q;
    order_d  = order_q;
    m_d      = m_q;
    pos_d    = pos_q;
    bit_d    = bit_q;
    digit_d  = digit_q;
    pool_d   = pool_q;
    seen_d   = seen_q;
    sum_d    = sum_q;
    ok_d     = ok_q;
    ovalid_d = ovalid_q && out_stall_i;
    oelem_d  = oelem_q;
    opos_d   = opos_q;
    olast_d  = olast_q;
    ook_d    = ook_q;
    oerr_d   = oerr_q;
    case (state_q)
      ST_IDLE: begin
        rank_d  = head_i.rank;
        order_d = head_i.order;
        m_d     = m_wide[ELEM_W-1:0];
        pos_d   = '0;
        bit_d   = 2'd3;
        digit_d = '0;
        for (int j = 0; j < POOL_N; j++) begin
          pool_d[j] = ELEM_W'(j + 1);
        end
        seen_d  = {{(MAX_ORDER-1){1'b0}}, 1'b1};
        sum_d   = '0;
        ok_d    = 1'b1;
      end
      ST_DIV: begin
        if ({3'b000, rank_q} >= trial) begin
          rank_d        = rank_q - trial[RANK_W-1:0];
          digit_d[bit_q] = 1'b1;
        end
        bit_d = bit_q - 2'd1;
      end
      ST_EMIT: begin
        if (out_free) begin
          for (int j = 0; j < POOL_N - 1; j++) begin
            if (ELEM_W'(j) >= di) begin
              pool_d[j] = pool_q[j+1];
            end
          end
          sum_d           = sum_new;
          seen_d[sum_new] = 1'b1;
          ok_d            = ok_new;
          pos_d           = pos_q + 4'd1;
          bit_d           = 2'd3;
          digit_d         = '0;
          ovalid_d        = 1'b1;
          oelem_d         = val;
          opos_d          = pos_q;
          olast_d         = is_last;
          ook_d           = is_last && ok_new;
          oerr_d          = 1'b0;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oelem_d  = '0;
          opos_d   = '0;
          olast_d  = 1'b1;
          ook_d    = 1'b0;
          oerr_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q   <= rank_d;
    order_q  <= order_d;
    m_q      <= m_d;
    pos_q    <= pos_d;
    bit_q    <= bit_d;
    digit_q  <= digit_d;
    pool_q   <= pool_d;
    seen_q   <= seen_d;
    sum_q    <= sum_d;
    ok_q     <= ok_d;
    oelem_q  <= oelem_d;
    opos_q   <= opos_d;
    olast_q  <= olast_d;
    ook_q    <= ook_d;
    oerr_q   <= oerr_d;
  end

  assign out_valid_o     = ovalid_q;
  assign element_o       = oelem_q;
  assign position_o      = opos_q;
  assign last_o          = olast_q;
  assign sequencing_ok_o = ook_q;
  assign index_error_o   = oerr_q;

endmodule

// File: rtl/permutation_unrank_sequencing_check.sv
// Top level of the permutation unranking block with the sequencing check.
// Depends on pusc_pkg, pusc_front, pusc_queue, pusc_back and assert_macros.svh.
//
// Usage. The configuration channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes the
// group order n; it is always ready, and the user must write it only while the block
// is idle, which the block itself does not enforce. Values below 4 or above 16 act
// as 4 or 16. Each request on the input channel carries one rank in perm_index_i and
// is taken when in_valid_i is high and in_stall_o is low. For a rank below (n-1)! the
// block returns n-1 results, one per element, with position counting up from 0 and
// last on the final one, which also carries sequencing_ok. A rank at or above (n-1)!
// returns one result with index_error and last set and the other fields zero.
// Operation. For each element the back part runs four restoring division steps for
// its factorial-base digit, then an emit step that removes the element from the pool
// and updates the prefix sum. A two-entry queue lets the front take further requests
// while the back part works.
// Reset clears the queue, the sequencer and the output valid, and sets n to 4.
// While a valid result is stalled, the result register holds and the next emit waits.
`include "assert_macros.svh"
module permutation_unrank_sequencing_check import pusc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ORDER_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [RANK_W-1:0]  perm_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ELEM_W-1:0]  element_o,
  output logic [ELEM_W-1:0]  position_o,
  output logic               last_o,
  output logic               sequencing_ok_o,
  output logic               index_error_o
);

  queue_status_t q_status;
  queue_entry_t  push_entry;
  queue_entry_t  head;
  logic          push;
  logic          pop;

  pusc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .perm_index_i (perm_index_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  pusc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  pusc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_o       (element_o),
    .position_o      (position_o),
    .last_o          (last_o),
    .sequencing_ok_o (sequencing_ok_o),
    .index_error_o   (index_error_o)
  );

  `PUSC_ASSERT(a_err_is_last, out_valid_o && index_error_o |-> last_o)
  `PUSC_ASSERT(a_err_zero, out_valid_o && index_error_o |-> element_o == 4'd0 && position_o == 4'd0 && !sequencing_ok_o)
  `PUSC_ASSERT(a_ok_only_last, out_valid_o && !last_o |-> !sequencing_ok_o)
  `PUSC_ASSERT_ALWAYS(a_queue_sane, !(q_status.full && q_status.empty))

endmodule
